FILE: rtl/clm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clm_pkg
// shared constants and types for the longest chain search block
// ----------------------------------------------------------------------------
package clm_pkg;

   localparam int MEMO_ENTRIES = 65536;
   localparam int MEMO_AW      = $clog2(MEMO_ENTRIES);

   localparam int LIMIT_W = 17;
   localparam int STEP_W  = 16;
   localparam int VALUE_W = 64;
   localparam int OVL_W   = 63;

   localparam logic [OVL_W-1:0]   OVL_RESET = 63'd3074457345618258602;
   localparam logic [VALUE_W-1:0] ODD_MAX   = 64'd6148914691236517204;
   localparam logic [STEP_W-1:0]  STEP_MAX  = '1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef struct packed {
      logic               done;
      logic               overflow;
      logic [STEP_W-1:0]  count;
      logic [VALUE_W-1:0] next_value;
      logic [STEP_W-1:0]  next_steps;
   } step_result_type;

endpackage
`default_nettype wire

FILE: rtl/clm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clm_if
// valid/ready channel interfaces for request, response and csr write
// ----------------------------------------------------------------------------
interface clm_req_if;
   import clm_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] upper_limit;
   modport source (output valid, output upper_limit, input ready);
   modport sink (input valid, input upper_limit, output ready);
endinterface

interface clm_rsp_if;
   import clm_pkg::*;
   logic               valid;
   logic               ready;
   logic               job_status;
   logic [LIMIT_W-1:0] best_number;
   logic [STEP_W-1:0]  best_steps;
   modport source (output valid, output job_status, output best_number,
                   output best_steps, input ready);
   modport sink (input valid, input job_status, input best_number,
                 input best_steps, output ready);
endinterface

interface clm_csr_if;
   import clm_pkg::*;
   logic             valid;
   logic             ready;
   logic [OVL_W-1:0] overflow_limit;
   modport source (output valid, output overflow_limit, input ready);
   modport sink (input valid, input overflow_limit, output ready);
endinterface
`default_nettype wire

FILE: rtl/clm_memo_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clm_memo_ram
// step count memo, one write port and one registered read port
// ----------------------------------------------------------------------------
module clm_memo_ram (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [clm_pkg::MEMO_AW-1:0]  wr_addr,
   input  wire  [clm_pkg::STEP_W-1:0]   wr_data,
   input  wire  [clm_pkg::MEMO_AW-1:0]  rd_addr,
   output logic [clm_pkg::STEP_W-1:0]   rd_data
);
   import clm_pkg::*;

   logic [STEP_W-1:0] memo_mem [MEMO_ENTRIES];
   logic [STEP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         memo_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= memo_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/clm_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clm_step_unit
// one chain step: end tests, memo hit, overflow tests and next value
// ----------------------------------------------------------------------------
module clm_step_unit (
   input  wire  [clm_pkg::VALUE_W-1:0] walk_value,
   input  wire  [clm_pkg::STEP_W-1:0]  walk_steps,
   input  wire  [clm_pkg::LIMIT_W-1:0] scan_start,
   input  wire  [clm_pkg::STEP_W-1:0]  memo_data,
   input  wire  [clm_pkg::OVL_W-1:0]   overflow_limit,
   output clm_pkg::step_result_type    result
);
   import clm_pkg::*;

   logic               is_one;
   logic               memo_hit;
   logic               over_limit;
   logic               odd_too_big;
   logic [STEP_W:0]    memo_sum;
   logic [STEP_W-1:0]  memo_count;
   logic [VALUE_W-1:0] tripled;

   always_comb begin
      is_one      = (walk_value == VALUE_W'(1));
      memo_hit    = (walk_value != VALUE_W'(scan_start)) &&
                    (walk_value <= VALUE_W'(MEMO_ENTRIES)) &&
                    (memo_data != '0);
      memo_sum    = {1'b0, walk_steps} + {1'b0, memo_data};
      memo_count  = memo_sum[STEP_W] ? STEP_MAX : memo_sum[STEP_W-1:0];
      over_limit  = walk_value > {1'b0, overflow_limit};
      odd_too_big = walk_value[0] && (walk_value > ODD_MAX);
      // 3v+1 as 2v+1 plus v
      tripled     = {walk_value[VALUE_W-2:0], 1'b1} + walk_value;

      result.done       = is_one || memo_hit;
      result.overflow   = !is_one && !memo_hit && (over_limit || odd_too_big);
      result.count      = is_one ? walk_steps : memo_count;
      result.next_value = walk_value[0] ? tripled : {1'b0, walk_value[VALUE_W-1:1]};
      result.next_steps = (walk_steps == STEP_MAX) ? STEP_MAX
                                                   : walk_steps + STEP_W'(1);
   end

endmodule
`default_nettype wire

FILE: rtl/collatz_longest_chain_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// collatz_longest_chain_search_top
// longest collatz chain search over 1..limit with a step count memo
// ----------------------------------------------------------------------------
// a request transaction on req_chan carries upper_limit (saturated to 65536).
// the block scans start numbers from the limit down to 1 and answers with one
// transaction on rsp_chan: job_status, best_number and best_steps. ties go to
// the largest start number; a sequence value above the overflow limit, or an
// odd value above ODD_MAX, ends the job with status 1, number 1 and steps 0.
// csr_chan writes the overflow limit and is always ready; the user must write it
// only while no job runs, as the block itself does not enforce this.
// after reset a clearing pass writes zero to all 65536 memo entries, one per
// cycle; req_chan is not ready until the pass is done.
// each start number takes a memo read and a check; if the memo holds no count,
// the start number is walked, with one memo read and one evaluate per chain step,
// and at the end the response register is loaded. the block then returns to
// idle to take the next request. one job at a time.
// the memo keeps its contents across jobs, so repeated jobs get faster.
// the response sits in an output register; a new request is taken while it
// waits, and a finished job waits in its last state until the register frees.
// ----------------------------------------------------------------------------
module collatz_longest_chain_search_top (
   input  wire       clock,
   input  wire       reset,
   clm_req_if.sink   req_chan,
   clm_rsp_if.source rsp_chan,
   clm_csr_if.sink   csr_chan
);
   import clm_pkg::*;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_SCAN_RD  = 3'd2;
   localparam logic [2:0] ST_SCAN_CHK = 3'd3;
   localparam logic [2:0] ST_WALK_RD  = 3'd4;
   localparam logic [2:0] ST_WALK_CHK = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]         state_ff,      state_in;
   logic [MEMO_AW-1:0] clear_addr_ff, clear_addr_in;
   logic [OVL_W-1:0]   ovl_ff,        ovl_in;
   logic [LIMIT_W-1:0] scan_ff,       scan_in;
   logic [VALUE_W-1:0] walk_value_ff, walk_value_in;
   logic [STEP_W-1:0]  walk_steps_ff, walk_steps_in;
   logic [LIMIT_W-1:0] best_start_ff, best_start_in;
   logic [STEP_W-1:0]  best_count_ff, best_count_in;
   logic               ovf_ff,        ovf_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [LIMIT_W-1:0] rsp_number_ff, rsp_number_in;
   logic [STEP_W-1:0]  rsp_steps_ff,  rsp_steps_in;

   logic               mem_we;
   logic [MEMO_AW-1:0] mem_waddr;
   logic [STEP_W-1:0]  mem_wdata;
   logic [MEMO_AW-1:0] mem_raddr;
   logic [STEP_W-1:0]  mem_rdata;
   logic [LIMIT_W-1:0] scan_minus;
   logic [LIMIT_W-1:0] req_limit;
   logic               finish;
   logic [STEP_W-1:0]  finish_count;
   step_result_type    step;

   clm_memo_ram u_memo (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   clm_step_unit u_step (
      .walk_value     (walk_value_ff),
      .walk_steps     (walk_steps_ff),
      .scan_start     (scan_ff),
      .memo_data      (mem_rdata),
      .overflow_limit (ovl_ff),
      .result         (step)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.job_status = rsp_status_ff;
   assign rsp_chan.best_number = rsp_number_ff;
   assign rsp_chan.best_steps = rsp_steps_ff;

   always_comb begin
      scan_minus = scan_ff - LIMIT_W'(1);
      req_limit  = (req_chan.upper_limit > LIMIT_W'(MEMO_ENTRIES)) ?
                   LIMIT_W'(MEMO_ENTRIES) : req_chan.upper_limit;

      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      ovl_in        = ovl_ff;
      scan_in       = scan_ff;
      walk_value_in = walk_value_ff;
      walk_steps_in = walk_steps_ff;
      best_start_in = best_start_ff;
      best_count_in = best_count_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_number_in = rsp_number_ff;
      rsp_steps_in  = rsp_steps_ff;

      mem_we       = 1'b0;
      mem_waddr    = scan_minus[MEMO_AW-1:0];
      mem_wdata    = '0;
      mem_raddr    = scan_minus[MEMO_AW-1:0];
      finish       = 1'b0;
      finish_count = mem_rdata;

      if (csr_chan.valid) begin
         ovl_in = csr_chan.overflow_limit;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            clear_addr_in = clear_addr_ff + MEMO_AW'(1);
            if (clear_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               scan_in       = req_limit;
               best_start_in = LIMIT_W'(1);
               best_count_in = '0;
               ovf_in        = 1'b0;
               state_in      = (req_limit == '0) ? ST_DONE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (mem_rdata == '0 && scan_ff != LIMIT_W'(1)) begin
               walk_value_in = VALUE_W'(scan_ff);
               walk_steps_in = '0;
               state_in      = ST_WALK_CHK;
            end else begin
               finish       = 1'b1;
               finish_count = mem_rdata;
            end
         end
         ST_WALK_RD: begin
            mem_raddr = walk_value_ff[MEMO_AW-1:0] - MEMO_AW'(1);
            state_in  = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (step.done) begin
               mem_we       = 1'b1;
               mem_wdata    = step.count;
               finish       = 1'b1;
               finish_count = step.count;
            end else if (step.overflow) begin
               ovf_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               walk_value_in = step.next_value;
               walk_steps_in = step.next_steps;
               state_in      = ST_WALK_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
               rsp_number_in = ovf_ff ? LIMIT_W'(1) : best_start_ff;
               rsp_steps_in  = ovf_ff ? '0 : best_count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // count for this start number is known: update best, move on
      if (finish) begin
         if (finish_count > best_count_ff) begin
            best_count_in = finish_count;
            best_start_in = scan_ff;
         end
         scan_in  = scan_minus;
         state_in = (scan_ff == LIMIT_W'(1)) ? ST_DONE : ST_SCAN_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         ovl_ff        <= OVL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         ovl_ff        <= ovl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      walk_value_ff <= walk_value_in;
      walk_steps_ff <= walk_steps_in;
      best_start_ff <= best_start_in;
      best_count_ff <= best_count_in;
      ovf_ff        <= ovf_in;
      rsp_status_ff <= rsp_status_in;
      rsp_number_ff <= rsp_number_in;
      rsp_steps_ff  <= rsp_steps_in;
   end

endmodule
`default_nettype wire
